/* design/sortable_value_store_top_assert.svh */
// Assertion macros for the sortable value store.
`ifndef SORTABLE_VALUE_STORE_TOP_ASSERT_SVH
`define SORTABLE_VALUE_STORE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/svs_pkg.sv */
// ----------------------------------------------------------------------------
// svs_pkg
// Types, codes and helpers shared by the sortable value store.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_SET    = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_SORT   = 3'd5;
    localparam logic [2:0] CMD_FIND   = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BOUND    = 3'd2;
    localparam logic [2:0] ST_SORTED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_ASC  = 2'd1;
    localparam logic [1:0] MARK_DSC  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] data_value;
        logic [9:0]         position;
        logic               sort_order;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_value;
        logic [9:0]         found_index;
        logic [10:0]        entry_total;
    } t_out;

    // one read and one write per cycle; sel 0 = main store, 1 = scratch
    typedef struct packed {
        logic              re;
        logic              rsel;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic              wsel;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
    } t_mem_req;

    function automatic logic less_than(input logic [31:0] a, input logic [31:0] b);
        less_than = $signed(a) < $signed(b);
    endfunction

    // a must come after b in the requested order
    function automatic logic goes_after(input logic [31:0] a, input logic [31:0] b,
                                        input logic desc);
        goes_after = desc ? less_than(a, b) : less_than(b, a);
    endfunction

endpackage

/* design/svs_ram.sv */
// ----------------------------------------------------------------------------
// svs_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module svs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/svs_seq.sv */
// ----------------------------------------------------------------------------
// svs_seq
// Command sequencer: one compare/address unit stepped over the stores.
// ----------------------------------------------------------------------------
module svs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  svs_pkg::t_in      i_cmd,
    output logic              o_idle,
    output svs_pkg::t_mem_req o_req,
    input  logic [31:0]       i_rdata_main,
    input  logic [31:0]       i_rdata_scr,
    output logic              o_res_valid,
    output svs_pkg::t_out     o_res,
    input  logic              i_res_take
);
    import svs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_RM_CAP = 4'd3;
    localparam logic [3:0] S_RM_RD  = 4'd4;
    localparam logic [3:0] S_RM_WR  = 4'd5;
    localparam logic [3:0] S_CP_RD  = 4'd6;
    localparam logic [3:0] S_CP_WR  = 4'd7;
    localparam logic [3:0] S_SI_ST  = 4'd8;
    localparam logic [3:0] S_SI_KEY = 4'd9;
    localparam logic [3:0] S_SI_CHK = 4'd10;
    localparam logic [3:0] S_SI_CMP = 4'd11;
    localparam logic [3:0] S_SR_CHK = 4'd12;
    localparam logic [3:0] S_SR_CMP = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0]       r_state, n_state;
    t_in              r_in, n_in;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_mark, n_mark;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [31:0]      r_key, n_key;
    logic             r_sel, n_sel;
    logic             r_dir, n_dir;
    logic             r_rdsel, n_rdsel;
    t_out             r_res, n_res;

    logic [31:0]      rdata;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] i_inc;
    logic [CNT_W-1:0] k_dec;
    logic [CNT_W-1:0] mid_calc;
    logic [1:0]       want;

    assign rdata    = r_rdsel ? i_rdata_scr : i_rdata_main;
    assign pos_ext  = CNT_W'(r_in.position);
    assign i_inc    = r_i + 1'b1;
    assign k_dec    = r_k - 1'b1;
    assign mid_calc = r_lo + ((r_hi - 1'b1 - r_lo) >> 1);
    assign want     = r_in.sort_order ? MARK_DSC : MARK_ASC;

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_cnt   = r_cnt;
        n_mark  = r_mark;
        n_i     = r_i;
        n_k     = r_k;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        n_sel   = r_sel;
        n_dir   = r_dir;
        n_res   = r_res;
        o_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_in    = i_cmd;
                    n_res   = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_in.command)
                    CMD_PUSH: begin
                        if (r_cnt >= CNT_W'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_req.we    = 1'b1;
                            o_req.waddr = r_cnt[ADDR_W-1:0];
                            o_req.wdata = r_in.data_value;
                            n_cnt       = r_cnt + 1'b1;
                            n_mark      = MARK_NONE;
                        end
                    end
                    CMD_POP: begin
                        if (r_cnt == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_cnt       = r_cnt - 1'b1;
                            o_req.re    = 1'b1;
                            o_req.raddr = n_cnt[ADDR_W-1:0];
                            n_state     = S_RDWAIT;
                        end
                    end
                    CMD_GET: begin
                        if (pos_ext >= r_cnt) begin
                            n_res.status = ST_BOUND;
                        end else begin
                            o_req.re    = 1'b1;
                            o_req.raddr = pos_ext[ADDR_W-1:0];
                            n_state     = S_RDWAIT;
                        end
                    end
                    CMD_SET: begin
                        if (pos_ext >= r_cnt) begin
                            n_res.status = ST_BOUND;
                        end else begin
                            o_req.we    = 1'b1;
                            o_req.waddr = pos_ext[ADDR_W-1:0];
                            o_req.wdata = r_in.data_value;
                            n_mark      = MARK_NONE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_ext >= r_cnt) begin
                            n_res.status = ST_BOUND;
                        end else begin
                            o_req.re    = 1'b1;
                            o_req.raddr = pos_ext[ADDR_W-1:0];
                            n_i         = pos_ext;
                            n_state     = S_RM_CAP;
                        end
                    end
                    CMD_SORT: begin
                        if (r_mark == want) begin
                            n_res.status = ST_SORTED;
                        end else begin
                            n_sel   = 1'b0;
                            n_dir   = r_in.sort_order;
                            n_i     = CNT_W'(1);
                            n_state = S_SI_ST;
                        end
                    end
                    CMD_FIND: begin
                        if (r_cnt == '0) begin
                            n_res.status = ST_EMPTY;
                        end else if (r_mark == MARK_NONE) begin
                            n_i     = '0;
                            n_state = S_CP_RD;
                        end else begin
                            n_sel   = 1'b0;
                            n_dir   = (r_mark == MARK_DSC);
                            n_lo    = '0;
                            n_hi    = r_cnt;
                            n_state = S_SR_CHK;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDWAIT: begin
                n_res.read_value = rdata;
                n_state          = S_DONE;
            end
            S_RM_CAP: begin
                n_res.read_value = rdata;
                n_state          = S_RM_RD;
            end
            S_RM_RD: begin
                if (i_inc < r_cnt) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = i_inc[ADDR_W-1:0];
                    n_state     = S_RM_WR;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RM_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_i[ADDR_W-1:0];
                o_req.wdata = rdata;
                n_i         = i_inc;
                n_state     = S_RM_RD;
            end
            S_CP_RD: begin
                if (r_i < r_cnt) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_i[ADDR_W-1:0];
                    n_state     = S_CP_WR;
                end else begin
                    n_sel   = 1'b1;
                    n_dir   = 1'b0;
                    n_i     = CNT_W'(1);
                    n_state = S_SI_ST;
                end
            end
            S_CP_WR: begin
                o_req.we    = 1'b1;
                o_req.wsel  = 1'b1;
                o_req.waddr = r_i[ADDR_W-1:0];
                o_req.wdata = rdata;
                n_i         = i_inc;
                n_state     = S_CP_RD;
            end
            // insertion sort on the selected store
            S_SI_ST: begin
                if (r_i < r_cnt) begin
                    o_req.re    = 1'b1;
                    o_req.rsel  = r_sel;
                    o_req.raddr = r_i[ADDR_W-1:0];
                    n_state     = S_SI_KEY;
                end else if (r_in.command == CMD_SORT) begin
                    n_mark  = want;
                    n_state = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_cnt;
                    n_state = S_SR_CHK;
                end
            end
            S_SI_KEY: begin
                n_key   = rdata;
                n_k     = r_i;
                n_state = S_SI_CHK;
            end
            S_SI_CHK: begin
                if (r_k == '0) begin
                    o_req.we    = 1'b1;
                    o_req.wsel  = r_sel;
                    o_req.waddr = '0;
                    o_req.wdata = r_key;
                    n_i         = i_inc;
                    n_state     = S_SI_ST;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.rsel  = r_sel;
                    o_req.raddr = k_dec[ADDR_W-1:0];
                    n_state     = S_SI_CMP;
                end
            end
            S_SI_CMP: begin
                o_req.we    = 1'b1;
                o_req.wsel  = r_sel;
                o_req.waddr = r_k[ADDR_W-1:0];
                if (goes_after(rdata, r_key, r_dir)) begin
                    o_req.wdata = rdata;
                    n_k         = k_dec;
                    n_state     = S_SI_CHK;
                end else begin
                    o_req.wdata = r_key;
                    n_i         = i_inc;
                    n_state     = S_SI_ST;
                end
            end
            // binary search over [lo, hi)
            S_SR_CHK: begin
                if (r_lo < r_hi) begin
                    o_req.re    = 1'b1;
                    o_req.rsel  = r_sel;
                    o_req.raddr = mid_calc[ADDR_W-1:0];
                    n_mid       = mid_calc;
                    n_state     = S_SR_CMP;
                end else begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end
            end
            S_SR_CMP: begin
                if (rdata == r_in.data_value) begin
                    n_res.found_index = r_mid[9:0];
                    n_state           = S_DONE;
                end else begin
                    if (less_than(r_in.data_value, rdata) != r_dir) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + 1'b1;
                    end
                    n_state = S_SR_CHK;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_rdsel = o_req.re ? o_req.rsel : r_rdsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mark  <= MARK_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mark  <= n_mark;
        end
        r_in    <= n_in;
        r_i     <= n_i;
        r_k     <= n_k;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_sel   <= n_sel;
        r_dir   <= n_dir;
        r_rdsel <= n_rdsel;
        r_res   <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res             = r_res;
        o_res.entry_total = r_cnt;
    end
endmodule

/* design/sortable_value_store_top.sv */
// ----------------------------------------------------------------------------
// sortable_value_store_top
// Bounded store of signed Q16.16 values with sort and binary search.
// ----------------------------------------------------------------------------
// One command per beat, one result beat per command. A single sequencer
// steps one compare/address unit over two 1024-entry RAMs (main store and a
// scratch copy), one read and one write per cycle, so the block takes one
// command at a time. Remove shifts the entries after the position down one
// place. Sort is an insertion sort, slowest on reversed data. Find on a
// sorted store is a binary search; on an unsorted store it first copies
// the entries to the scratch copy and sorts it ascending, then searches
// that. The result sits in an output register, so the next command can be
// accepted while a result waits to be taken.
// Store contents are not cleared at reset; only written entries are read.
module sortable_value_store_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  svs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output svs_pkg::t_out o_out_data
);
    import svs_pkg::*;

    t_mem_req    req;
    logic [31:0] rdata_main;
    logic [31:0] rdata_scr;
    logic        seq_idle;
    logic        res_valid;
    t_out        res;
    logic        res_take;
    logic        r_out_valid;
    t_out        r_out_data;

    // result register is free when empty or being drained this cycle
    assign res_take   = res_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = seq_idle;

    svs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && seq_idle),
        .i_cmd        (i_in_data),
        .o_idle       (seq_idle),
        .o_req        (req),
        .i_rdata_main (rdata_main),
        .i_rdata_scr  (rdata_scr),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    // main store
    svs_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_main (
        .i_clk   (i_clk),
        .i_we    (req.we && !req.wsel),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re && !req.rsel),
        .i_raddr (req.raddr),
        .o_rdata (rdata_main)
    );

    // scratch copy, sorted ascending for find on unsorted contents
    svs_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_scr (
        .i_clk   (i_clk),
        .i_we    (req.we && req.wsel),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re && req.rsel),
        .i_raddr (req.raddr),
        .o_rdata (rdata_scr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

/* design/svs_checker.sv */
// ----------------------------------------------------------------------------
// svs_checker
// Port-level checks for the sortable value store.
// ----------------------------------------------------------------------------
`include "sortable_value_store_top_assert.svh"

module svs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input svs_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input svs_pkg::t_out o_out_data
);
    import svs_pkg::*;

    `SVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat dropped or changed while stalled")
    `SVS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready stayed high after a command beat")
    `SVS_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, o_out_valid, o_out_data.entry_total <= 11'(CAPACITY), "entry total beyond capacity")
    `SVS_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), (o_out_data.read_value == '0) && (o_out_data.found_index == '0), "failed command returned data")
endmodule

bind sortable_value_store_top svs_checker u_svs_checker (.*);

/* verif/sortable_value_store_top_test.sv */
// ----------------------------------------------------------------------------
// sortable_value_store_top_test
// Self-checking bench for the sortable value store. A queue of command beats,
// directed, random, then a fill to capacity, feeds a clocked driver. A clocked monitor
// predicts each accepted command against its own store model and checks every
// result beat field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sortable_value_store_top_test;
    import svs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // well above the longest legal quiet stretch
    localparam int RANDOM_BEATS   = 400;
    localparam int SMALL_FILL     = 40;     // random part keeps the store small (sort is an insertion sort)

    typedef struct {
        t_in beat;
        bit  drain;   // hold this beat back until every result is in
    } pending_t;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    sortable_value_store_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Store model: contents, fill level and sort mark as seen by commands
    // ------------------------------------------------------------------
    int         store_model[CAPACITY];
    int         fill_model;
    logic [1:0] order_mark;

    pending_t pending_beats[$];
    t_out     expected_results[$];

    int issued_beats;
    int accepted_beats;
    int checked_results;
    int mismatch_count;
    int quiet_cycles;
    int gen_fill;          // fill level tracked while building stimulus
    int cmd_seen[8];

    // plain insertion sort on a copy; any correct sort gives the same words
    task automatic order_values(ref int vals[$], input bit desc);
        int key;
        int j;
        for (int i = 1; i < vals.size(); i++) begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && (desc ? vals[j] < key : vals[j] > key)) begin
                vals[j+1] = vals[j];
                j--;
            end
            vals[j+1] = key;
        end
    endtask

    // binary search probing lo + (hi - lo) / 2; -1 when absent
    function automatic int search_values(ref int vals[$], input int key, input bit desc);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = vals.size() - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (vals[mid] == key)
                return mid;
            if ((key < vals[mid]) != desc)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    task automatic predict_result(input t_in b, output t_out r);
        int vals[$];
        int hit;
        logic [1:0] want;
        r = '0;
        case (b.command)
            CMD_PUSH: begin
                if (fill_model >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    store_model[fill_model] = b.data_value;
                    fill_model++;
                    order_mark = MARK_NONE;
                end
            end
            CMD_POP: begin
                if (fill_model == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    fill_model--;
                    r.read_value = store_model[fill_model];
                end
            end
            CMD_GET: begin
                if (b.position >= fill_model)
                    r.status = ST_BOUND;
                else
                    r.read_value = store_model[b.position];
            end
            CMD_SET: begin
                if (b.position >= fill_model) begin
                    r.status = ST_BOUND;
                end else begin
                    store_model[b.position] = b.data_value;
                    order_mark = MARK_NONE;
                end
            end
            CMD_REMOVE: begin
                if (b.position >= fill_model) begin
                    r.status = ST_BOUND;
                end else begin
                    r.read_value = store_model[b.position];
                    for (int i = b.position; i + 1 < fill_model; i++)
                        store_model[i] = store_model[i+1];
                    fill_model--;
                end
            end
            CMD_SORT: begin
                want = b.sort_order ? MARK_DSC : MARK_ASC;
                if (order_mark == want) begin
                    r.status = ST_SORTED;
                end else begin
                    for (int i = 0; i < fill_model; i++)
                        vals.push_back(store_model[i]);
                    order_values(vals, b.sort_order);
                    for (int i = 0; i < fill_model; i++)
                        store_model[i] = vals[i];
                    order_mark = want;
                end
            end
            CMD_FIND: begin
                if (fill_model == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < fill_model; i++)
                        vals.push_back(store_model[i]);
                    // unsorted store: search an ascending scratch copy
                    if (order_mark == MARK_NONE)
                        order_values(vals, 1'b0);
                    hit = search_values(vals, b.data_value, order_mark == MARK_DSC);
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else
                        r.found_index = hit[9:0];
                end
            end
            default: ;  // unknown command leaves everything alone
        endcase
        r.entry_total = fill_model[10:0];
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 checked_results, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders; gen_fill follows the fill level so positions and
    // pushes can be aimed
    // ------------------------------------------------------------------
    task automatic add_beat(input logic [2:0] cmd, input logic [31:0] val,
                            input logic [9:0] pos, input logic ord, input bit drain = 0);
        pending_t p;
        p.beat.command    = cmd;
        p.beat.data_value = val;
        p.beat.position   = pos;
        p.beat.sort_order = ord;
        p.drain           = drain;
        pending_beats.push_back(p);
        case (cmd)
            CMD_PUSH:   if (gen_fill < CAPACITY) gen_fill++;
            CMD_POP:    if (gen_fill > 0) gen_fill--;
            CMD_REMOVE: if (pos < gen_fill) gen_fill--;
            default: ;
        endcase
    endtask

    // mostly a handful of Q16.16 values so duplicates and find hits are common
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 70)
            return ($urandom_range(10) - 5) <<< 16;
        return $urandom;
    endfunction

    function automatic logic [9:0] pick_position();
        if ($urandom_range(99) < 80)
            return 10'($urandom_range(gen_fill));   // includes the first bad index
        return 10'($urandom_range(1023));
    endfunction

    task automatic add_random_beat(input bit drain);
        int r;
        logic [2:0] cmd;
        r = $urandom_range(99);
        if (r < 30)      cmd = (gen_fill < SMALL_FILL) ? CMD_PUSH : CMD_POP;
        else if (r < 45) cmd = CMD_POP;
        else if (r < 58) cmd = CMD_GET;
        else if (r < 68) cmd = CMD_SET;
        else if (r < 76) cmd = CMD_REMOVE;
        else if (r < 84) cmd = CMD_SORT;
        else if (r < 98) cmd = CMD_FIND;
        else             cmd = 3'd7;
        add_beat(cmd, pick_value(), pick_position(), 1'($urandom_range(1)), drain);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: new beat at the falling edge once the last one was taken.
    // Accepted beats 600 to 899 run with no idling on either side.
    // ------------------------------------------------------------------
    int idle_pct;
    assign idle_pct = (accepted_beats >= 600 && accepted_beats < 900) ? 0 : 13;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            out_ready <= ($urandom_range(99) >= idle_pct);
            if (!(in_valid && accepted_beats != issued_beats)) begin
                if (pending_beats.size() != 0
                    && !(pending_beats[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= idle_pct) begin
                    in_data  <= pending_beats[0].beat;
                    in_valid <= 1'b1;
                    void'(pending_beats.pop_front());
                    issued_beats++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats, then predict the command beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("result beat with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.status != want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.read_value != want.read_value)
                        report_mismatch("read_value", out_data.read_value, want.read_value);
                    if (out_data.found_index != want.found_index)
                        report_mismatch("found_index", out_data.found_index,
                                        want.found_index);
                    if (out_data.entry_total != want.entry_total)
                        report_mismatch("entry_total", out_data.entry_total,
                                        want.entry_total);
                end
                checked_results++;
            end
            if (in_valid && in_ready) begin
                predict_result(in_data, want);
                expected_results.push_back(want);
                cmd_seen[in_data.command]++;
                accepted_beats++;
            end
            // watchdog: long runs of cycles with no beat on either side
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        fill_model = 0;
        order_mark = MARK_NONE;
        gen_fill   = 0;
        issued_beats = 0;
        accepted_beats = 0;
        checked_results = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;

        // directed: empty store corner cases, then a small hand-built store
        add_beat(CMD_POP,  32'h0, 10'd0, 1'b0);
        add_beat(CMD_FIND, 32'h0, 10'd0, 1'b0);
        add_beat(CMD_GET,  32'h0, 10'd0, 1'b0);
        add_beat(CMD_SORT, 32'h0, 10'd0, 1'b0);     // empty sort marks sorted
        add_beat(CMD_SORT, 32'h0, 10'd0, 1'b0);     // already sorted
        add_beat(CMD_PUSH, 32'h7FFF_FFFF, 10'd0, 1'b0);
        add_beat(CMD_PUSH, 32'h8000_0000, 10'd0, 1'b0);
        add_beat(CMD_PUSH, 32'h0, 10'd0, 1'b0);
        add_beat(CMD_PUSH, 32'h0001_8000, 10'd0, 1'b0);
        add_beat(CMD_SET,  32'hFFFF_0000, 10'd1, 1'b0);
        add_beat(CMD_GET,  32'h0, 10'd4, 1'b0);     // first bad index
        add_beat(CMD_SET,  32'h0, 10'd1023, 1'b0);
        add_beat(CMD_REMOVE, 32'h0, 10'd1023, 1'b0);
        add_beat(CMD_SORT, 32'h0, 10'd0, 1'b1);
        add_beat(CMD_FIND, 32'h0, 10'd0, 1'b0);     // search on descending store
        add_beat(CMD_FIND, 32'h1234_5678, 10'd0, 1'b0);
        add_beat(CMD_SORT, 32'h0, 10'd0, 1'b1);
        add_beat(CMD_REMOVE, 32'h0, 10'd1, 1'b0);   // order kept after remove
        add_beat(CMD_FIND, 32'h0001_8000, 10'd0, 1'b0);
        add_beat(CMD_PUSH, 32'h0, 10'd0, 1'b0);     // duplicates, unsorted again
        add_beat(CMD_PUSH, 32'h0, 10'd0, 1'b0);
        add_beat(CMD_FIND, 32'h0, 10'd0, 1'b0);     // scratch copy search
        add_beat(3'd7, 32'hFFFF_FFFF, 10'h3FF, 1'b1);
        add_beat(CMD_SORT, 32'h0, 10'd0, 1'b0);
        add_beat(CMD_FIND, 32'h7FFF_FFFF, 10'd0, 1'b0);

        // random, with a pause for all results every couple hundred beats
        for (int n = 0; n < RANDOM_BEATS; n++)
            add_random_beat(n % 200 == 199);

        // fill to capacity, touch the top index and the full store
        add_beat(CMD_PUSH, $urandom, 10'd0, 1'b0, 1);
        while (gen_fill < CAPACITY)
            add_beat(CMD_PUSH, $urandom, 10'd0, 1'b0);
        add_beat(CMD_PUSH, 32'h1, 10'd0, 1'b0);     // full
        add_beat(CMD_GET, 32'h0, 10'd1023, 1'b0);
        add_beat(CMD_SET, 32'h8000_0000, 10'd1023, 1'b0);
        add_beat(CMD_GET, 32'h0, 10'd1023, 1'b0);
        add_beat(CMD_REMOVE, 32'h0, 10'd0, 1'b0);
        add_beat(CMD_GET, 32'h0, 10'd1023, 1'b0);   // now out of bound

        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("%0d commands, %0d results checked: push %0d pop %0d get %0d set %0d",
                 accepted_beats, checked_results, cmd_seen[0], cmd_seen[1], cmd_seen[2],
                 cmd_seen[3]);
        $display("remove %0d sort %0d find %0d unknown %0d; store filled to capacity once",
                 cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
